### design/bpra_pkg.sv
// Shared types and constants for the bitmap page range allocator.
`default_nettype none

package bpra_pkg;

  // Default sizes
  localparam int unsigned POOL_PAGES_DEF = 4096;
  localparam int unsigned PAGE_BYTES_DEF = 4096;

  // Request codes
  localparam logic FUNC_FREE = 1'b1;
  localparam logic [1:0] POOL_PAGED   = 2'd2;
  localparam logic [1:0] POOL_INVALID = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_NONPAGED_BASE  = 2'd0;
  localparam logic [1:0] CFG_PAGED_BASE     = 2'd1;
  localparam logic [1:0] CFG_NONPAGED_PAGES = 2'd2;
  localparam logic [1:0] CFG_PAGED_PAGES    = 2'd3;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_SPACE  = 3'd1,
    ST_BAD_SIZE  = 3'd2,
    ST_BAD_POOL  = 3'd3,
    ST_BAD_ADDR  = 3'd4,
    ST_BEYOND    = 3'd5,
    ST_NOT_ALLOC = 3'd6
  } status_t;

  // Controller states
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_MOD, S_START, S_SCAN_RD, S_SCAN,
    S_CLAIM, S_RD, S_WR, S_REWIND, S_FIN
  } ctl_state_t;

  // What the word read-modify-write loop does
  typedef enum logic [1:0] {
    M_SET, M_CHK, M_CLR
  } mode_t;

  // Datapath operations, one per cycle
  typedef enum logic [3:0] {
    OP_NONE, OP_CLEAR, OP_LOAD, OP_CHECK, OP_MOD, OP_START, OP_SCAN_RD,
    OP_SCAN, OP_CLAIM, OP_RD, OP_SET, OP_CHK, OP_CLR, OP_REWIND, OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;   // last entry of the clearing pass
    logic chk_ok;     // request passed its checks
    logic func_free;  // latched request is a free
    logic mod_last;   // last step of the remainder unit
    logic scan_hit;   // current page completes the run
    logic scan_last;  // current page is the last one to scan
    logic scan_rd;    // next page lies in another word
    logic word_last;  // current word is the last of the range
    logic chk_fail;   // a page of the current word is not in use
    logic out_free;   // result register can take a result
  } dp_stat_t;

endpackage

`default_nettype wire

### design/bitmap_page_range_allocator_core.sv
// Top level of the bitmap page range allocator: controller plus datapath.
//
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid/in_stall, func, pool, byte_count,     | request
//          | free_address                                   |
//  out     | out_valid/out_stall, status, address           | result
//  cfg     | cfg_we, cfg_index, cfg_wdata                   | write only
//
// One request at a time. Allocate: the remainder unit first reduces the hint, then
// the scan takes one page per cycle through the bitmap (up to the pool's page
// count), pausing for a memory read at each new word; then each claimed word is read and written.
// Free: each word is read and checked, then read and cleared; rejects go to the result.
// After reset a clearing pass writes every bitmap word, one per cycle, with
// in_stall high.
// A finished result waits in the output register while the next request enters.
`default_nettype none

module bitmap_page_range_allocator_core #(
  parameter int unsigned POOL_PAGES = bpra_pkg::POOL_PAGES_DEF,
  parameter int unsigned PAGE_BYTES = bpra_pkg::PAGE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [1:0]  in_pool,
  input  logic [31:0] in_byte_count,
  input  logic [63:0] in_free_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [63:0] out_address,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  bpra_pkg::dp_cmd_t  cmd;
  bpra_pkg::dp_stat_t stat;

  // Sequencer
  bpra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Bitmaps, checks and result register
  bpra_datapath #(
    .POOL_PAGES (POOL_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_func         (in_func),
    .in_pool         (in_pool),
    .in_byte_count   (in_byte_count),
    .in_free_address (in_free_address),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_address     (out_address)
  );

endmodule

`default_nettype wire

### design/bpra_datapath.sv
// Datapath: configuration, hints, bitmap memory, remainder unit, scan and range logic.
`default_nettype none

module bpra_datapath #(
  parameter int unsigned POOL_PAGES = bpra_pkg::POOL_PAGES_DEF,
  parameter int unsigned PAGE_BYTES = bpra_pkg::PAGE_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bpra_pkg::dp_cmd_t  cmd,
  output bpra_pkg::dp_stat_t stat,
  input  logic               in_func,
  input  logic [1:0]         in_pool,
  input  logic [31:0]        in_byte_count,
  input  logic [63:0]        in_free_address,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_wdata,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [63:0]        out_address
);

  localparam int unsigned PW = ($clog2(POOL_PAGES) > 7) ? $clog2(POOL_PAGES) : 7;
  localparam int unsigned WW = PW - 6;
  localparam int unsigned MEM_DEPTH = 2 ** (WW + 1);
  localparam int unsigned HW = $clog2(POOL_PAGES + 1);
  localparam int unsigned LB = $clog2(PAGE_BYTES);
  localparam int unsigned NPW = 33 - LB;
  localparam int unsigned CW = $clog2(HW);

  // Configuration and per-pool hints
  logic [63:0]    np_base_r, pg_base_r;
  logic [12:0]    np_pages_r, pg_pages_r;
  logic [HW-1:0]  np_hint_r, pg_hint_r;

  // Latched request
  logic              func_r, psel_r, one_r;
  bpra_pkg::status_t pre_st_r, status_r;
  logic [NPW-1:0]    pages_r;
  logic [63:0]       va_r, base_r, addr_r;
  logic [HW-1:0]     total_r, hint_r;

  // Remainder unit
  logic [HW-1:0] rem_r, mx_r, md_r;
  logic [CW-1:0] mcnt_r;

  // Scan and range
  logic [PW-1:0] cur_r, rs_r, beg_r, end_r;
  logic [HW-1:0] left_r, run_r;
  logic [WW-1:0] wd_r;

  // Bitmap memory, both pools
  logic [63:0] mem [MEM_DEPTH];
  logic [63:0] rdata_r;
  logic [WW:0] clr_r;

  // Result register
  logic              out_valid_r;
  bpra_pkg::status_t out_status_r;
  logic [63:0]       out_address_r;

  bpra_pkg::dp_op_t op;
  assign op = cmd.op;

  // Request intake: pool select, page count clamp, rounding
  logic              sel_paged;
  logic [12:0]       praw;
  logic [HW-1:0]     total_in;
  logic [32:0]       pages_sum;
  bpra_pkg::status_t pre_in;

  always_comb begin
    sel_paged = (in_pool == bpra_pkg::POOL_PAGED);
    praw = sel_paged ? pg_pages_r : np_pages_r;
    if (praw == 13'd0) begin
      total_in = HW'(1);
    end else if (32'(praw) > 32'(POOL_PAGES)) begin
      total_in = HW'(POOL_PAGES);
    end else begin
      total_in = HW'(praw);
    end
    pages_sum = {1'b0, in_byte_count} + 33'(PAGE_BYTES - 1);
    if (in_byte_count == 32'd0) begin
      pre_in = bpra_pkg::ST_BAD_SIZE;
    end else if (in_pool == bpra_pkg::POOL_INVALID) begin
      pre_in = bpra_pkg::ST_BAD_POOL;
    end else begin
      pre_in = bpra_pkg::ST_OK;
    end
  end

  // Request checks
  logic [32:0]       pages33, tot33, end33;
  logic [63:0]       off, idx_w;
  bpra_pkg::status_t chk_st;

  always_comb begin
    pages33 = 33'(pages_r);
    tot33 = 33'(total_r);
    off = va_r - base_r;
    idx_w = off >> LB;
    end33 = 33'(idx_w[HW-1:0]) + pages33 - 33'd1;
    if (pre_st_r != bpra_pkg::ST_OK) begin
      chk_st = pre_st_r;
    end else if (func_r != bpra_pkg::FUNC_FREE) begin
      chk_st = (pages33 > tot33) ? bpra_pkg::ST_NO_SPACE : bpra_pkg::ST_OK;
    end else if (va_r < base_r || off[LB-1:0] != '0 || idx_w >= 64'(total_r)) begin
      chk_st = bpra_pkg::ST_BAD_ADDR;
    end else if (pages33 > tot33 || 33'(idx_w[HW-1:0]) > tot33 - pages33) begin
      chk_st = bpra_pkg::ST_BEYOND;
    end else begin
      chk_st = bpra_pkg::ST_OK;
    end
  end

  // Remainder step: restoring, one bit a cycle
  logic [HW:0] mt;
  logic        mge;
  assign mt  = {rem_r, mx_r[HW-1]};
  assign mge = (mt >= {1'b0, md_r});

  // Scan step over one page
  logic          bit_used, hit;
  logic [HW-1:0] run_base, run_new, cur_inc;
  logic [PW-1:0] rs_n, cur_nxt;

  always_comb begin
    bit_used = rdata_r[cur_r[5:0]];
    run_base = (cur_r == '0) ? '0 : run_r;
    run_new = run_base + HW'(1);
    hit = !bit_used && (33'(run_new) == pages33);
    rs_n = (run_base == '0) ? cur_r : rs_r;
    cur_inc = HW'(cur_r) + HW'(1);
    cur_nxt = (cur_inc == total_r) ? '0 : cur_inc[PW-1:0];
  end

  // Bit mask of the range within the current word
  logic [5:0]  lo, hi;
  logic [63:0] mask;
  logic        word_last;

  always_comb begin
    word_last = (wd_r == end_r[PW-1:6]);
    lo = (wd_r == beg_r[PW-1:6]) ? beg_r[5:0] : 6'd0;
    hi = word_last ? end_r[5:0] : 6'd63;
    mask = ({64{1'b1}} << lo) & ({64{1'b1}} >> (6'd63 - hi));
  end

  // Memory port controls
  logic          mem_we, mem_re;
  logic [WW:0]   mem_wa, mem_ra;
  logic [63:0]   mem_wd;

  always_comb begin
    mem_we = (op == bpra_pkg::OP_CLEAR) || (op == bpra_pkg::OP_SET) ||
             (op == bpra_pkg::OP_CLR);
    mem_re = (op == bpra_pkg::OP_SCAN_RD) || (op == bpra_pkg::OP_RD);
    mem_wa = (op == bpra_pkg::OP_CLEAR) ? clr_r : {psel_r, wd_r};
    mem_ra = (op == bpra_pkg::OP_SCAN_RD) ? {psel_r, cur_r[PW-1:6]} : {psel_r, wd_r};
    case (op)
      bpra_pkg::OP_SET: mem_wd = rdata_r | mask;
      bpra_pkg::OP_CLR: mem_wd = rdata_r & ~mask;
      default:          mem_wd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_ra];
    end
  end

  // Status to the controller
  always_comb begin
    stat.clr_last  = &clr_r;
    stat.chk_ok    = (chk_st == bpra_pkg::ST_OK);
    stat.func_free = (func_r == bpra_pkg::FUNC_FREE);
    stat.mod_last  = (mcnt_r == CW'(HW - 1));
    stat.scan_hit  = hit;
    stat.scan_last = (left_r == HW'(1));
    stat.scan_rd   = (cur_nxt[5:0] == 6'd0);
    stat.word_last = word_last;
    stat.chk_fail  = ((rdata_r & mask) != mask);
    stat.out_free  = !out_valid_r || !out_stall;
  end

  // Control state: configuration, hints, clear counter, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      np_base_r   <= '0;
      pg_base_r   <= '0;
      np_pages_r  <= 13'd4096;
      pg_pages_r  <= 13'd4096;
      np_hint_r   <= '0;
      pg_hint_r   <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bpra_pkg::CFG_NONPAGED_BASE:  np_base_r  <= cfg_wdata;
          bpra_pkg::CFG_PAGED_BASE:     pg_base_r  <= cfg_wdata;
          bpra_pkg::CFG_NONPAGED_PAGES: np_pages_r <= cfg_wdata[12:0];
          bpra_pkg::CFG_PAGED_PAGES:    pg_pages_r <= cfg_wdata[12:0];
          default: ;
        endcase
      end
      if (op == bpra_pkg::OP_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      // hint moves just past the claimed run
      if (op == bpra_pkg::OP_CLAIM) begin
        if (psel_r) begin
          pg_hint_r <= HW'(33'(rs_r) + pages33);
        end else begin
          np_hint_r <= HW'(33'(rs_r) + pages33);
        end
      end
      if (op == bpra_pkg::OP_OUT) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (op)
      bpra_pkg::OP_LOAD: begin
        func_r   <= in_func;
        psel_r   <= sel_paged;
        pages_r  <= pages_sum[32:LB];
        one_r    <= (pages_sum[32:LB] == NPW'(1));
        va_r     <= in_free_address;
        base_r   <= sel_paged ? pg_base_r : np_base_r;
        total_r  <= total_in;
        hint_r   <= sel_paged ? pg_hint_r : np_hint_r;
        pre_st_r <= pre_in;
      end
      bpra_pkg::OP_CHECK: begin
        status_r <= chk_st;
        beg_r    <= idx_w[PW-1:0];
        end_r    <= end33[PW-1:0];
        wd_r     <= idx_w[PW-1:6];
        mx_r     <= one_r ? (hint_r >> 6) : hint_r;
        md_r     <= one_r ? HW'((33'(total_r) + 33'd63) >> 6) : total_r;
        rem_r    <= '0;
        mcnt_r   <= '0;
        left_r   <= total_r;
        run_r    <= '0;
        addr_r   <= '0;
      end
      bpra_pkg::OP_MOD: begin
        rem_r  <= mge ? HW'(mt - {1'b0, md_r}) : mt[HW-1:0];
        mx_r   <= mx_r << 1;
        mcnt_r <= mcnt_r + 1'b1;
      end
      bpra_pkg::OP_START: begin
        // one page starts at the hint's word, longer runs at the hint
        cur_r <= one_r ? PW'({rem_r, 6'd0}) : rem_r[PW-1:0];
      end
      bpra_pkg::OP_SCAN: begin
        run_r  <= bit_used ? '0 : run_new;
        rs_r   <= rs_n;
        cur_r  <= cur_nxt;
        left_r <= left_r - HW'(1);
        if (!hit && left_r == HW'(1)) begin
          status_r <= bpra_pkg::ST_NO_SPACE;
        end
      end
      bpra_pkg::OP_CLAIM: begin
        beg_r  <= rs_r;
        end_r  <= PW'(33'(rs_r) + pages33 - 33'd1);
        wd_r   <= rs_r[PW-1:6];
        addr_r <= base_r + (64'(rs_r) << LB);
      end
      bpra_pkg::OP_SET, bpra_pkg::OP_CLR: begin
        wd_r <= wd_r + 1'b1;
      end
      bpra_pkg::OP_CHK: begin
        wd_r <= wd_r + 1'b1;
        if ((rdata_r & mask) != mask) begin
          status_r <= bpra_pkg::ST_NOT_ALLOC;
        end
      end
      bpra_pkg::OP_REWIND: begin
        wd_r <= beg_r[PW-1:6];
      end
      bpra_pkg::OP_OUT: begin
        out_status_r  <= status_r;
        out_address_r <= (status_r == bpra_pkg::ST_OK && func_r != bpra_pkg::FUNC_FREE) ?
                         addr_r : 64'd0;
      end
      default: ;
    endcase
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_address = out_address_r;

endmodule

`default_nettype wire

### design/bpra_ctrl.sv
// Controller state machine that sequences the allocator datapath.
`default_nettype none

module bpra_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bpra_pkg::dp_stat_t stat,
  output bpra_pkg::dp_cmd_t  cmd
);

  bpra_pkg::ctl_state_t state_r, state_nxt;
  bpra_pkg::mode_t      mode_r, mode_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bpra_pkg::S_CLEAR;
      mode_r  <= bpra_pkg::M_SET;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
    end
  end

  // Next state and datapath command
  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    cmd.op    = bpra_pkg::OP_NONE;
    in_stall  = 1'b1;
    case (state_r)
      bpra_pkg::S_CLEAR: begin
        cmd.op = bpra_pkg::OP_CLEAR;
        if (stat.clr_last) begin
          state_nxt = bpra_pkg::S_IDLE;
        end
      end
      bpra_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op    = bpra_pkg::OP_LOAD;
          state_nxt = bpra_pkg::S_CHECK;
        end
      end
      bpra_pkg::S_CHECK: begin
        cmd.op = bpra_pkg::OP_CHECK;
        if (!stat.chk_ok) begin
          state_nxt = bpra_pkg::S_FIN;
        end else if (stat.func_free) begin
          state_nxt = bpra_pkg::S_RD;
          mode_nxt  = bpra_pkg::M_CHK;
        end else begin
          state_nxt = bpra_pkg::S_MOD;
        end
      end
      bpra_pkg::S_MOD: begin
        cmd.op = bpra_pkg::OP_MOD;
        if (stat.mod_last) begin
          state_nxt = bpra_pkg::S_START;
        end
      end
      bpra_pkg::S_START: begin
        cmd.op    = bpra_pkg::OP_START;
        state_nxt = bpra_pkg::S_SCAN_RD;
      end
      bpra_pkg::S_SCAN_RD: begin
        cmd.op    = bpra_pkg::OP_SCAN_RD;
        state_nxt = bpra_pkg::S_SCAN;
      end
      bpra_pkg::S_SCAN: begin
        cmd.op = bpra_pkg::OP_SCAN;
        if (stat.scan_hit) begin
          state_nxt = bpra_pkg::S_CLAIM;
        end else if (stat.scan_last) begin
          state_nxt = bpra_pkg::S_FIN;
        end else if (stat.scan_rd) begin
          state_nxt = bpra_pkg::S_SCAN_RD;
        end
      end
      bpra_pkg::S_CLAIM: begin
        cmd.op    = bpra_pkg::OP_CLAIM;
        state_nxt = bpra_pkg::S_RD;
        mode_nxt  = bpra_pkg::M_SET;
      end
      bpra_pkg::S_RD: begin
        cmd.op    = bpra_pkg::OP_RD;
        state_nxt = bpra_pkg::S_WR;
      end
      bpra_pkg::S_WR: begin
        case (mode_r)
          bpra_pkg::M_CHK: cmd.op = bpra_pkg::OP_CHK;
          bpra_pkg::M_CLR: cmd.op = bpra_pkg::OP_CLR;
          default:         cmd.op = bpra_pkg::OP_SET;
        endcase
        if (mode_r == bpra_pkg::M_CHK && stat.chk_fail) begin
          state_nxt = bpra_pkg::S_FIN;
        end else if (!stat.word_last) begin
          state_nxt = bpra_pkg::S_RD;
        end else if (mode_r == bpra_pkg::M_CHK) begin
          state_nxt = bpra_pkg::S_REWIND;
        end else begin
          state_nxt = bpra_pkg::S_FIN;
        end
      end
      bpra_pkg::S_REWIND: begin
        cmd.op    = bpra_pkg::OP_REWIND;
        state_nxt = bpra_pkg::S_RD;
        mode_nxt  = bpra_pkg::M_CLR;
      end
      bpra_pkg::S_FIN: begin
        if (stat.out_free) begin
          cmd.op    = bpra_pkg::OP_OUT;
          state_nxt = bpra_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bpra_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/bpra_checker.sv
// Port-level checker for the allocator core, bound to the top level.
`default_nettype none

module bpra_assertions (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [63:0] out_address
);

  // one request in work at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in work");

  // status codes stay in their defined set
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= bpra_pkg::ST_NOT_ALLOC)
    else $error("undefined status code");

  // failed requests report no address
  a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != bpra_pkg::ST_OK |-> out_address == 64'd0)
    else $error("address reported with error status");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_address))
    else $error("stalled result changed");

endmodule

bind bitmap_page_range_allocator_core bpra_assertions u_bpra_assertions (.*);

`default_nettype wire
